[design/fsr_pkg.sv]
// Package for the fp64 to fp32 stochastic rounding block.
// Holds hash constants, field widths and the stage-to-stage structs.
package fsr_pkg;
    localparam int unsigned LdWidth     = 16;

    localparam logic [31:0] HashMulCol = 32'h9e3779b9;
    localparam logic [31:0] HashMulLd  = 32'h85ebca6b;
    localparam logic [31:0] MixMulA    = 32'h7feb352d;
    localparam logic [31:0] MixMulB    = 32'h846ca68b;
    localparam logic [31:0] ExpInfNan  = 32'h7f800000;
    localparam logic [31:0] QuietNan   = 32'h7fc00000;
    localparam logic [31:0] MaxFinite  = 32'h7f7fffff;

    // Result of the decode stage: truncated fp32 pattern and the dropped part.
    typedef struct packed {
        logic        sign;
        logic        fixed;     // result already final (special, exact, overflow)
        logic [31:0] res;       // final result, or truncated magnitude when not fixed
        logic [52:0] rem;       // dropped bits, below 2^sh
        logic [6:0]  sh;        // number of dropped bits, capped at 77
    } t_dec;
endpackage

[design/fsr_hash.sv]
// Per-element hash pipeline: seed multiply, two mixing multiplies.
// Depends on fsr_pkg. Four register stages, gated by the shared advance.
module fsr_hash #(
    parameter int unsigned INDEX_WIDTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_adv,
    input  logic [INDEX_WIDTH-1:0]     i_row,
    input  logic [INDEX_WIDTH-1:0]     i_col,
    input  logic [fsr_pkg::LdWidth-1:0] i_ld,
    output logic [23:0]                o_rnd
);
    import fsr_pkg::*;

    logic [31:0] r_seed, r_m1, r_m2, r_rnd;
    logic [31:0] n_seed, x1, x2;

    always_comb begin
        n_seed = 32'(i_row) ^ (32'(i_col) * HashMulCol) ^ (32'(i_ld) * HashMulLd);
        x1 = r_seed ^ (r_seed >> 16);
        x2 = r_m1 ^ (r_m1 >> 15);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_seed <= n_seed;
            r_m1   <= x1 * MixMulA;
            r_m2   <= x2 * MixMulB;
            r_rnd  <= r_m2 ^ (r_m2 >> 16);
        end
    end

    assign o_rnd = r_rnd[23:0];
endmodule

[design/fsr_decode.sv]
// Decode of the binary64 input into a truncated binary32 and the dropped part.
// Depends on fsr_pkg. Purely combinational; the caller registers the result.
module fsr_decode (
    input  logic [63:0]     i_value,
    output fsr_pkg::t_dec   o_dec
);
    import fsr_pkg::*;

    logic        s;
    logic [10:0] e;
    logic [51:0] m;
    logic [52:0] sig;
    logic [10:0] shw;
    logic [6:0]  sh;
    logic [31:0] tb;
    logic [52:0] rem;

    always_comb begin
        s   = i_value[63];
        e   = i_value[62:52];
        m   = i_value[51:0];
        sig = {(e != 11'd0), m};
        shw = (e != 11'd0) ? (11'd926 - e) : 11'd925;
        if (e >= 11'd897) begin
            sh  = 7'd29;
            tb  = {1'b0, 8'(e - 11'd896), sig[51:29]};
            rem = {24'd0, sig[28:0]};
        end else if (shw < 11'd64) begin
            sh  = 7'(shw);
            tb  = 32'(sig >> shw[5:0]);
            rem = sig & ~(53'h1f_ffff_ffff_ffff << shw[5:0]);
        end else begin
            // Beyond 77 dropped bits the compare no longer sees any of rem's top part
            sh  = (shw < 11'd77) ? 7'(shw) : 7'd77;
            tb  = 32'd0;
            rem = sig;
        end
        o_dec.sign = s;
        o_dec.sh   = sh;
        o_dec.rem  = rem;
        o_dec.res  = tb;
        o_dec.fixed = 1'b1;
        if (e == 11'h7ff) begin
            o_dec.res = (m != 52'd0) ? (QuietNan | 32'(m[51:29])) : ExpInfNan;
        end else if (e == 11'd0 && m == 52'd0) begin
            o_dec.res = 32'd0;
        end else if (e >= 11'd1151) begin
            o_dec.res = ExpInfNan;
        end else if (rem == 53'd0) begin
            o_dec.res = tb;
        end else if (tb == MaxFinite) begin
            o_dec.res = ExpInfNan;
        end else begin
            o_dec.fixed = 1'b0;
        end
    end
endmodule

[design/fp64_to_fp32_stochastic_round.sv]
// Top level of the fp64 to fp32 stochastic rounding block.
// Depends on fsr_pkg, fsr_hash and fsr_decode.
//
// One item per cycle while the output is not stalled, through five register
// stages, with o_valid taken from the last. The pipeline depth is set by the hash: a seed
// multiply and two mixing multiplies each get a register stage, with the
// binary64 decode travelling alongside and the integer compare against the
// dropped fraction in the last stage. A stall on the output holds the whole
// pipe; the input is taken whenever the last stage is empty or its item leaves
// in the same cycle.
module fp64_to_fp32_stochastic_round #(
    parameter int unsigned INDEX_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [63:0]                 i_value_bits,
    input  logic [INDEX_WIDTH-1:0]      i_row_index,
    input  logic [INDEX_WIDTH-1:0]      i_col_index,
    input  logic                        i_cfg_we,
    input  logic [fsr_pkg::LdWidth-1:0] i_cfg_data,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [31:0]                 o_result_bits
);
    import fsr_pkg::*;

    localparam int unsigned Depth = 5;

    logic [LdWidth-1:0] r_ld;
    logic [Depth-1:0]   r_vld;
    logic               adv;
    t_dec               dec;
    t_dec               r_d1, r_d2, r_d3, r_d4;
    logic [23:0]        rnd;
    logic [31:0]        r_res;
    logic               up, lt, gt;
    logic [24:0]        a;
    logic [5:0]         t;
    logic [52:0]        q, low;
    logic [76:0]        rhs;
    logic [31:0]        n_res;

    assign adv     = !(r_vld[Depth-1] && i_stall);
    assign o_stall = !adv;
    assign o_valid = r_vld[Depth-1];
    assign o_result_bits = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ld  <= LdWidth'(1);
            r_vld <= '0;
        end else begin
            if (i_cfg_we) r_ld <= i_cfg_data;
            if (adv) r_vld <= {r_vld[Depth-2:0], i_valid};
        end
    end

    fsr_hash #(.INDEX_WIDTH(INDEX_WIDTH)) u_hash (
        .i_clk (i_clk),
        .i_adv (adv),
        .i_row (i_row_index),
        .i_col (i_col_index),
        .i_ld  (r_ld),
        .o_rnd (rnd)
    );

    fsr_decode u_dec (
        .i_value (i_value_bits),
        .o_dec   (dec)
    );

    // Compare a/2^24 with rem/2^sh; a is r for negative values, 2^24-r otherwise.
    always_comb begin
        a   = r_d4.sign ? {1'b0, rnd} : (25'h100_0000 - {1'b0, rnd});
        t   = 6'd0;
        q   = 53'd0;
        low = 53'd0;
        rhs = 77'd0;
        lt  = 1'b0;
        gt  = 1'b0;
        if (r_d4.sh <= 7'd24) begin
            rhs = 77'(r_d4.rem) << (5'd24 - 5'(r_d4.sh));
            gt  = 77'(a) > rhs;
            lt  = 77'(a) < rhs;
        end else begin
            if (r_d4.sh < 7'd77) begin
                t   = 6'(r_d4.sh - 7'd24);
                q   = r_d4.rem >> t;
                low = r_d4.rem & ~(53'h1f_ffff_ffff_ffff << t);
            end else begin
                q   = 53'd0;
                low = r_d4.rem;
            end
            gt = 53'(a) > q;
            lt = (53'(a) < q) || ((53'(a) == q) && (low != 53'd0));
        end
        up = r_d4.sign ? lt : !gt;
        n_res = r_d4.fixed ? r_d4.res : (r_d4.res + 32'(up));
        n_res[31] = r_d4.sign;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d1  <= dec;
            r_d2  <= r_d1;
            r_d3  <= r_d2;
            r_d4  <= r_d3;
            r_res <= n_res;
        end
    end

    // Output holds while stalled.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_bits))
        else $error("stalled result changed");
    // Pipe stall is driven exactly by the last stage.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("stall mismatch");
    // Reset empties the pipe.
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");
endmodule
